FILE: rtl/enig_pkg.sv
// enig_pkg: shared types, constants and lookup functions for the rotor cipher core.
// Stands alone; every other file in rtl/ except enig_checker imports it.
`timescale 1ns / 1ps

package enig_pkg;

  localparam int LETTERS = 26;

  // Configuration register indexes
  localparam logic [2:0] CFG_LEFT_ROTOR   = 3'd0;
  localparam logic [2:0] CFG_MIDDLE_ROTOR = 3'd1;
  localparam logic [2:0] CFG_RIGHT_ROTOR  = 3'd2;
  localparam logic [2:0] CFG_RIGHT_START  = 3'd3;
  localparam logic [2:0] CFG_MIDDLE_START = 3'd4;
  localparam logic [2:0] CFG_LEFT_START   = 3'd5;
  localparam logic [2:0] CFG_REFLECTOR    = 3'd6;

  localparam logic [4:0] POS_Z = 5'd25;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

  localparam logic [26*8-1:0] ROTOR_WIRING [8] = '{
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK",
    "JPGVOUMFYQBENHZRDKASXLICTW",
    "NZJHGRCXMYSWBOUFAIVLPEKQDT",
    "FKQHTLXOCBJSPDZRAMEWNIUYGV"
  };

  localparam logic [26*8-1:0] REFLECTOR_WIRING [3] = '{
    "EJMZALYXVBWFCRQUONTSPIKHGD",
    "YRUHQSLDPXNGOKMIEBFZCWVJAT",
    "FVPJIAOYEDRZXWGCTKUQSBNMHL"
  };

  // Wiring choice, already reduced to table indexes
  typedef struct packed {
    logic [2:0] wl;
    logic [2:0] wm;
    logic [2:0] wr;
    logic [1:0] refl;
  } rotor_sel_t;

  // One classified character, queued between front and back
  typedef struct packed {
    logic       bad;
    logic [4:0] x;
    logic [4:0] p1;
    logic [4:0] p2;
    logic [4:0] p3;
  } q_entry_t;

  function automatic logic [4:0] add26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(LETTERS)) s = s - 6'(LETTERS);
    return s[4:0];
  endfunction

  function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + 6'(LETTERS) - {1'b0, b};
    return s[4:0];
  endfunction

  function automatic logic [4:0] step26(input logic [4:0] p);
    return (p >= POS_Z) ? 5'd0 : 5'(p + 5'd1);
  endfunction

  // Fold a raw start value of 26..31 back into range
  function automatic logic [4:0] start_load(input logic [4:0] v);
    return (v >= 5'(LETTERS)) ? 5'(v - 5'(LETTERS)) : v;
  endfunction

  function automatic logic [2:0] wiring_idx(input logic [3:0] num);
    return 3'(num[2:0] + 3'd7);
  endfunction

  function automatic logic [4:0] notch_of(input logic [2:0] w);
    logic [4:0] n;
    unique case (w)
      3'd0:    n = 5'd17;
      3'd1:    n = 5'd5;
      3'd2:    n = 5'd22;
      3'd3:    n = 5'd10;
      3'd4:    n = 5'd25;
      default: n = 5'd13;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] rotor_fwd(input logic [2:0] w, input logic [4:0] i);
    logic [7:0] ch;
    ch = ROTOR_WIRING[w][8*(25-int'(i)) +: 8];
    return 5'(ch - ASCII_UPPER_A);
  endfunction

  // Inverse wiring: match against all 26 contacts in parallel
  function automatic logic [4:0] rotor_inv(input logic [2:0] w, input logic [4:0] v);
    logic [4:0] k_hit;
    k_hit = 5'd0;
    for (int k = 0; k < LETTERS; k++) begin
      if (rotor_fwd(w, 5'(k)) == v) k_hit = 5'(k);
    end
    return k_hit;
  endfunction

  function automatic logic [4:0] reflect(input logic [1:0] r, input logic [4:0] i);
    logic [7:0] ch;
    ch = REFLECTOR_WIRING[r][8*(25-int'(i)) +: 8];
    return 5'(ch - ASCII_UPPER_A);
  endfunction

endpackage

FILE: rtl/three_rotor_enigma_cipher_core.sv
// three_rotor_enigma_cipher_core: top level of the three-rotor cipher.
// Depends on enig_pkg, enig_front, enig_queue and enig_back.
`timescale 1ns / 1ps
//
//  Channel | Direction | Beat contents                     | Handshake
//  --------+-----------+-----------------------------------+----------------------
//  in_     | input     | in_char_in[7:0], in_restart       | in_valid / in_stall
//  out_    | output    | out_letter_out[4:0], out_bad_char | out_valid / out_stall
//  cfg_    | input     | cfg_index[2:0], cfg_wdata[4:0]    | cfg_wr_en, no wait
//
//  One character beat is taken per cycle while the queue has room; each result
//  is registered by the queue write, the forward stage and the return stage, in
//  that order, before it is presented; the last two form the two-stage encipher
//  pipeline in enig_back. Rotor stepping in enig_front is combinational on each
//  accepted beat, so beats follow back to back. A stalled output holds the
//  pipeline; the queue (QUEUE_DEPTH beats) absorbs input until full, then
//  in_stall rises. Synchronous reset restores the default rotor order 1-2-3,
//  reflector B and all positions at A.

module three_rotor_enigma_cipher_core import enig_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_letter_out,
  output logic       out_bad_char,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_wdata
);

  logic [3:0] left_rotor_r, middle_rotor_r, right_rotor_r;
  logic [4:0] right_start_r, middle_start_r, left_start_r;
  logic [1:0] reflector_select_r;

  rotor_sel_t sel;
  q_entry_t   front_entry, head_entry;
  logic       in_accept, q_full, q_head_valid, q_pop;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_rotor_r       <= 4'd1;
      middle_rotor_r     <= 4'd2;
      right_rotor_r      <= 4'd3;
      right_start_r      <= 5'd0;
      middle_start_r     <= 5'd0;
      left_start_r       <= 5'd0;
      reflector_select_r <= 2'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LEFT_ROTOR:   left_rotor_r       <= cfg_wdata[3:0];
        CFG_MIDDLE_ROTOR: middle_rotor_r     <= cfg_wdata[3:0];
        CFG_RIGHT_ROTOR:  right_rotor_r      <= cfg_wdata[3:0];
        CFG_RIGHT_START:  right_start_r      <= cfg_wdata;
        CFG_MIDDLE_START: middle_start_r     <= cfg_wdata;
        CFG_LEFT_START:   left_start_r       <= cfg_wdata;
        CFG_REFLECTOR:    reflector_select_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Map rotor numbers onto wiring tables; select code 3 behaves as reflector B
  always_comb begin
    sel.wl   = wiring_idx(left_rotor_r);
    sel.wm   = wiring_idx(middle_rotor_r);
    sel.wr   = wiring_idx(right_rotor_r);
    sel.refl = (reflector_select_r == 2'd3) ? 2'd1 : reflector_select_r;
  end

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  enig_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .char_in      (in_char_in),
    .restart      (in_restart),
    .right_start  (right_start_r),
    .middle_start (middle_start_r),
    .left_start   (left_start_r),
    .sel          (sel),
    .entry        (front_entry)
  );

  enig_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_entry (front_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_entry (head_entry)
  );

  enig_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_head_valid),
    .head_entry     (head_entry),
    .sel            (sel),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_letter_out (out_letter_out),
    .out_bad_char   (out_bad_char)
  );

endmodule

FILE: rtl/enig_front.sv
// enig_front: accepts characters, classifies them and advances the rotor positions.
// Depends on enig_pkg; feeds enig_queue.
`timescale 1ns / 1ps

module enig_front import enig_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_in,
  input  logic       restart,
  input  logic [4:0] right_start,
  input  logic [4:0] middle_start,
  input  logic [4:0] left_start,
  input  rotor_sel_t sel,
  output q_entry_t   entry
);

  logic [4:0] right_pos_r, middle_pos_r, left_pos_r;
  logic [4:0] right_pos_nxt, middle_pos_nxt, left_pos_nxt;
  logic [4:0] base_r, base_m, base_l;
  logic [4:0] r1, m1, m2, l2;
  logic       is_upper, is_lower, is_letter;
  logic       mid_kick, double_step;

  always_comb begin
    base_r = restart ? start_load(right_start)  : right_pos_r;
    base_m = restart ? start_load(middle_start) : middle_pos_r;
    base_l = restart ? start_load(left_start)   : left_pos_r;

    is_upper  = (char_in >= ASCII_UPPER_A) && (char_in <= ASCII_UPPER_Z);
    is_lower  = (char_in >= ASCII_LOWER_A) && (char_in <= ASCII_LOWER_Z);
    is_letter = is_upper || is_lower;

    // right rotor steps first, middle follows on the right notch
    r1       = step26(base_r);
    mid_kick = (r1 == notch_of(sel.wr)) || ((sel.wr >= 3'd5) && (r1 == POS_Z));
    m1       = mid_kick ? step26(base_m) : base_m;

    // double step once the middle rotor reaches turnover
    double_step = (({1'b0, m1} + 6'd1) == {1'b0, notch_of(sel.wm)}) ||
                  ((sel.wm >= 3'd5) && (m1 == POS_Z));
    m2 = double_step ? step26(m1)     : m1;
    l2 = double_step ? step26(base_l) : base_l;

    entry.bad = !is_letter;
    entry.x   = is_upper ? 5'(char_in - ASCII_UPPER_A) : 5'(char_in - ASCII_LOWER_A);
    entry.p1  = r1;
    entry.p2  = m1;
    entry.p3  = base_l;

    right_pos_nxt  = right_pos_r;
    middle_pos_nxt = middle_pos_r;
    left_pos_nxt   = left_pos_r;
    if (accept) begin
      if (is_letter) begin
        right_pos_nxt  = r1;
        middle_pos_nxt = m2;
        left_pos_nxt   = l2;
      end else begin
        right_pos_nxt  = base_r;
        middle_pos_nxt = base_m;
        left_pos_nxt   = base_l;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_pos_r  <= 5'd0;
      middle_pos_r <= 5'd0;
      left_pos_r   <= 5'd0;
    end else begin
      right_pos_r  <= right_pos_nxt;
      middle_pos_r <= middle_pos_nxt;
      left_pos_r   <= left_pos_nxt;
    end
  end

endmodule

FILE: rtl/enig_queue.sv
// enig_queue: short FIFO of classified characters between front and back.
// Depends on enig_pkg for the entry type.
`timescale 1ns / 1ps

module enig_queue import enig_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output q_entry_t head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t       store [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    if (push && !pop) count_nxt = CW'(count_r + 1'b1);
    if (pop && !push) count_nxt = CW'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr_r] <= push_entry;
  end

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = store[rd_ptr_r];

endmodule

FILE: rtl/enig_back.sv
// enig_back: two-stage encipher pipeline (forward plus reflector, then return path).
// Depends on enig_pkg; drains enig_queue and drives the result channel.
`timescale 1ns / 1ps

module enig_back import enig_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  q_entry_t   head_entry,
  input  rotor_sel_t sel,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_letter_out,
  output logic       out_bad_char
);

  logic       a_valid_r, a_valid_nxt;
  logic       a_bad_r;
  logic [4:0] a_e_r, a_p1_r, a_p2_r, a_p3_r;
  logic       o_valid_r, o_valid_nxt;
  logic [4:0] o_letter_r;
  logic       o_bad_r;
  logic       out_load, a_load;
  logic [4:0] f1, f2, f3, fr;
  logic [4:0] b1, b2, b3;

  assign out_load = !o_valid_r || !out_stall;
  assign a_load   = !a_valid_r || out_load;
  assign pop      = head_valid && a_load;

  // forward through right, middle, left, then reflect
  always_comb begin
    f1 = rotor_fwd(sel.wr, add26(head_entry.x, head_entry.p1));
    f2 = rotor_fwd(sel.wm, add26(f1, sub26(head_entry.p2, head_entry.p1)));
    f3 = rotor_fwd(sel.wl, add26(f2, sub26(head_entry.p3, head_entry.p2)));
    fr = reflect(sel.refl, sub26(f3, head_entry.p3));
  end

  // return through inverse left, middle, right
  always_comb begin
    b1 = sub26(rotor_inv(sel.wl, add26(a_e_r, a_p3_r)), a_p3_r);
    b2 = sub26(rotor_inv(sel.wm, add26(b1, a_p2_r)), a_p2_r);
    b3 = sub26(rotor_inv(sel.wr, add26(b2, a_p1_r)), a_p1_r);
  end

  assign a_valid_nxt = a_load   ? head_valid : a_valid_r;
  assign o_valid_nxt = out_load ? a_valid_r  : o_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_bad_r <= head_entry.bad;
      a_e_r   <= fr;
      a_p1_r  <= head_entry.p1;
      a_p2_r  <= head_entry.p2;
      a_p3_r  <= head_entry.p3;
    end
    if (out_load) begin
      o_bad_r    <= a_bad_r;
      o_letter_r <= a_bad_r ? 5'd0 : b3;
    end
  end

  assign out_valid      = o_valid_r;
  assign out_letter_out = o_letter_r;
  assign out_bad_char   = o_bad_r;

endmodule

FILE: rtl/enig_checker.sv
// enig_checker: port-level checks on the cipher core, bound to the top level.
// Depends on three_rotor_enigma_cipher_core's ports only.
`timescale 1ns / 1ps

module enig_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] out_letter_out,
  input logic       out_bad_char
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_letter_out) && $stable(out_bad_char))
    else $error("stalled result beat changed");

  // a rejected character carries letter zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_char |-> out_letter_out == 5'd0)
    else $error("bad character beat with non-zero letter");

  // enciphered letters stay within A..Z
  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_char |-> out_letter_out <= 5'd25)
    else $error("enciphered letter out of range");

  // after reset no result is valid and the input is not stalled
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind three_rotor_enigma_cipher_core enig_checker u_enig_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_letter_out (out_letter_out),
  .out_bad_char   (out_bad_char)
);
